@@ src/periodic_task_scheduler_defines.svh @@
// Assertion macros for the periodic task scheduler checker.
// Needs a clock named clock and a reset named reset in the scope of use.
`ifndef PERIODIC_TASK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PTS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/pts_pkg.sv @@
// Shared constants, result codes and controller/datapath interface types
// for the periodic task scheduler. No dependencies.
package pts_pkg;

   localparam int MAX_TASKS  = 16;
   localparam int TIME_BITS  = 32;
   localparam int TAG_BITS   = 16;
   localparam int KIND_BITS  = 3;
   localparam int SLOT_BITS  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int COUNT_BITS = $clog2(MAX_TASKS + 1);
   localparam int PORT_SLOT_BITS = 4;

   localparam logic FUNC_CREATE = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   localparam logic [KIND_BITS-1:0] KIND_CREATED = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_FULL    = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_REPORT  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_WRAP    = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_EMPTY   = 3'd4;

   typedef struct packed {
      logic                 latch;
      logic                 create;
      logic                 single;
      logic [KIND_BITS-1:0] kind;
      logic                 tick;
      logic                 walk_init;
      logic                 rd;
      logic                 report;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic full;
      logic wrap;
      logic empty;
      logic walk_done;
      logic out_free;
   } status_type;

endpackage

@@ src/periodic_task_scheduler.sv @@
// Top level of the periodic task scheduler.
// Depends on pts_pkg, pts_ctrl and pts_datapath.
//
// The block takes one request word at a time and is busy until its last
// result word has been loaded into the output register. A create request,
// a tick that finds the timer wrapped and a tick on an empty table each
// pass from idle through the decide state, which loads their single result
// word. A tick on a table holding N tasks goes from the decide state
// through a read state and a report state for every task: one for the
// registered read of the task tables and one to form its report. The next
// request is accepted while the final result still waits in the output
// register. Stalls on the result side hold the decide and report states
// until the output register is free.
module periodic_task_scheduler import pts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_now_time,
   input  logic [31:0] req_period,
   input  logic [15:0] req_task_tag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_slot,
   output logic        rsp_run_now,
   output logic [31:0] rsp_elapsed,
   output logic [15:0] rsp_tag_out,
   output logic        rsp_last
);

   cmd_type    cmd;
   status_type status;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pts_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_func     (req_func),
      .req_now_time (req_now_time),
      .req_period   (req_period),
      .req_task_tag (req_task_tag),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_slot     (rsp_slot),
      .rsp_run_now  (rsp_run_now),
      .rsp_elapsed  (rsp_elapsed),
      .rsp_tag_out  (rsp_tag_out),
      .rsp_last     (rsp_last)
   );

endmodule

@@ src/pts_ctrl.sv @@
// Sequencing state machine of the periodic task scheduler.
// Depends on pts_pkg; drives commands into pts_datapath.
module pts_ctrl import pts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECIDE = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_REPORT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.func == FUNC_CREATE) begin
               if (status.out_free) begin
                  cmd.create = !status.full;
                  cmd.single = 1'b1;
                  cmd.kind   = status.full ? KIND_FULL : KIND_CREATED;
                  state_in   = ST_IDLE;
               end
            end else if (status.wrap || status.empty) begin
               if (status.out_free) begin
                  cmd.tick   = 1'b1;
                  cmd.single = 1'b1;
                  cmd.kind   = status.wrap ? KIND_WRAP : KIND_EMPTY;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.tick      = 1'b1;
               cmd.walk_init = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (status.out_free) begin
               cmd.report = 1'b1;
               state_in   = status.walk_done ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

@@ src/pts_datapath.sv @@
// Task tables, timer registers, walk index and result register of the
// periodic task scheduler. Depends on pts_pkg; commanded by pts_ctrl.
module pts_datapath import pts_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      req_func,
   input  logic [31:0]               req_now_time,
   input  logic [31:0]               req_period,
   input  logic [15:0]               req_task_tag,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_kind,
   output logic [3:0]                rsp_slot,
   output logic                      rsp_run_now,
   output logic [31:0]               rsp_elapsed,
   output logic [15:0]               rsp_tag_out,
   output logic                      rsp_last
);

   logic [TIME_BITS-1:0] period_mem [MAX_TASKS];
   logic [TIME_BITS-1:0] last_mem   [MAX_TASKS];
   logic [TAG_BITS-1:0]  tag_mem    [MAX_TASKS];

   logic                  func_ff, func_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [TIME_BITS-1:0]  period_ff, period_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TIME_BITS-1:0]  prev_ff, prev_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   logic [TIME_BITS-1:0]  rd_period_ff;
   logic [TIME_BITS-1:0]  rd_last_ff;
   logic [TAG_BITS-1:0]   rd_tag_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0]  kind_ff, kind_in;
   logic [3:0]            slot_ff, slot_in;
   logic                  run_ff, run_in;
   logic [31:0]           elapsed_ff, elapsed_in;
   logic [15:0]           tag_out_ff, tag_out_in;
   logic                  last_ff, last_in;

   logic [SLOT_BITS-1:0]  count_slot;
   logic [COUNT_BITS-1:0] count_dec;
   logic [TIME_BITS-1:0]  elapsed_w;
   logic                  due_w;
   logic [SLOT_BITS-1:0]  last_waddr;
   logic                  last_we;

   assign count_slot = count_ff[SLOT_BITS-1:0];
   assign count_dec  = count_ff - COUNT_BITS'(1);
   assign elapsed_w  = now_ff - rd_last_ff;
   assign due_w      = (rd_period_ff == '0) || (elapsed_w > rd_period_ff);
   assign last_we    = cmd.create || (cmd.report && due_w);
   assign last_waddr = cmd.create ? count_slot : idx_ff;

   always_comb begin
      status.func      = func_ff;
      status.full      = (count_ff == COUNT_BITS'(MAX_TASKS));
      status.wrap      = (now_ff < prev_ff);
      status.empty     = (count_ff == '0);
      status.walk_done = (idx_ff == '0);
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      func_in   = cmd.latch ? req_func : func_ff;
      now_in    = cmd.latch ? req_now_time : now_ff;
      period_in = cmd.latch ? req_period : period_ff;
      tag_in    = cmd.latch ? req_task_tag : tag_ff;
      count_in  = cmd.create ? count_ff + COUNT_BITS'(1) : count_ff;
      prev_in   = cmd.tick ? now_ff : prev_ff;
      idx_in    = idx_ff;
      if (cmd.walk_init) begin
         idx_in = count_dec[SLOT_BITS-1:0];
      end else if (cmd.report) begin
         idx_in = idx_ff - SLOT_BITS'(1);
      end
   end

   always_comb begin
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      run_in       = run_ff;
      elapsed_in   = elapsed_ff;
      tag_out_in   = tag_out_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.report) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_REPORT;
         slot_in      = PORT_SLOT_BITS'(idx_ff);
         run_in       = due_w;
         elapsed_in   = elapsed_w;
         tag_out_in   = rd_tag_ff;
         last_in      = (idx_ff == '0);
      end else if (cmd.single) begin
         rsp_valid_in = 1'b1;
         kind_in      = cmd.kind;
         slot_in      = (cmd.kind == KIND_CREATED) ? PORT_SLOT_BITS'(count_slot) : '0;
         run_in       = 1'b0;
         elapsed_in   = '0;
         tag_out_in   = '0;
         last_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.create) begin
         period_mem[count_slot] <= period_ff;
         tag_mem[count_slot]    <= tag_ff;
      end
      if (last_we) begin
         last_mem[last_waddr] <= now_ff;
      end
      if (cmd.rd) begin
         rd_period_ff <= period_mem[idx_ff];
         rd_last_ff   <= last_mem[idx_ff];
         rd_tag_ff    <= tag_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      now_ff     <= now_in;
      period_ff  <= period_in;
      tag_ff     <= tag_in;
      idx_ff     <= idx_in;
      kind_ff    <= kind_in;
      slot_ff    <= slot_in;
      run_ff     <= run_in;
      elapsed_ff <= elapsed_in;
      tag_out_ff <= tag_out_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = kind_ff;
   assign rsp_slot    = slot_ff;
   assign rsp_run_now = run_ff;
   assign rsp_elapsed = elapsed_ff;
   assign rsp_tag_out = tag_out_ff;
   assign rsp_last    = last_ff;

endmodule

@@ src/pts_checker.sv @@
// Port-level assertions for the periodic task scheduler, bound to the top.
// Depends on pts_pkg and periodic_task_scheduler_defines.svh.
`include "periodic_task_scheduler_defines.svh"

module pts_checker import pts_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_kind,
   input logic [3:0]  rsp_slot,
   input logic        rsp_run_now,
   input logic [31:0] rsp_elapsed,
   input logic [15:0] rsp_tag_out,
   input logic        rsp_last
);

   logic        rsp_held;
   logic        req_accept;
   logic        rsp_report;
   logic        rsp_single;
   logic        rsp_clean;
   logic [56:0] rsp_word;

   assign rsp_held   = rsp_valid && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_report = rsp_valid && (rsp_kind == KIND_REPORT);
   assign rsp_single = rsp_valid && (rsp_kind != KIND_REPORT);
   assign rsp_clean  = rsp_last && !rsp_run_now && (rsp_elapsed == '0) && (rsp_tag_out == '0);
   assign rsp_word   = {rsp_kind, rsp_slot, rsp_run_now, rsp_elapsed, rsp_tag_out, rsp_last};

   `PTS_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_word), "stalled word changed")
   `PTS_ASSERT_NEXT(a_busy_after_accept, req_accept, req_stall, "request accepted while busy")
   `PTS_ASSERT_IMPL(a_single_is_last, rsp_single, rsp_clean, "non-report word not clean and final")
   `PTS_ASSERT_IMPL(a_slot_zero_last, rsp_report, rsp_last == (rsp_slot == '0), "walk end not at slot zero")

endmodule

bind periodic_task_scheduler pts_checker u_pts_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_kind    (rsp_kind),
   .rsp_slot    (rsp_slot),
   .rsp_run_now (rsp_run_now),
   .rsp_elapsed (rsp_elapsed),
   .rsp_tag_out (rsp_tag_out),
   .rsp_last    (rsp_last)
);
